[hdl/kct_pkg.sv]
// kct_pkg: shared types and codes for the keyed contact table.
// Holds the request opcodes, result status codes and the transaction structs.
// No dependencies.
package kct_pkg;

  typedef enum logic [1:0] {
    OP_MERGE  = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STS_ADDED     = 3'd0,
    STS_PRESENT   = 3'd1,
    STS_FULL      = 3'd2,
    STS_REMOVED   = 3'd3,
    STS_NOT_FOUND = 3'd4,
    STS_READ      = 3'd5
  } status_e;

  // One stored contact.
  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [63:0] alias_high;
    logic [63:0] alias_low;
  } contact_t;

  // Classified request, front to back.
  typedef struct packed {
    op_e         op;
    contact_t    con;
    logic [3:0]  idx;
    logic        null_con;
    logic        in_range;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    status_e     status;
    logic [3:0]  slot_used;
    logic        entry_valid;
    contact_t    con;
  } res_t;

endpackage

[hdl/kct_fifo.sv]
// kct_fifo: small first-in first-out queue of flat words.
// Used for the request queue and the result queue; no package dependency.
module kct_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[hdl/kct_front.sv]
// kct_front: accepts request transactions, classifies them and queues them.
// Depends on kct_pkg and kct_fifo.
module kct_front #(
  parameter int SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  logic [1:0]     op_i,
  input  logic [31:0]    ip_addr_i,
  input  logic [15:0]    port_num_i,
  input  logic [63:0]    alias_high_i,
  input  logic [63:0]    alias_low_i,
  input  logic [3:0]     slot_index_i,
  input  logic           cmd_pop_i,
  output kct_pkg::cmd_t  cmd_o,
  output logic           cmd_empty_o
);

  kct_pkg::cmd_t            cmd_in;
  logic [$bits(kct_pkg::cmd_t)-1:0] cmd_flat;

  // All-zero contact, and read index check against the table size.
  always_comb begin
    cmd_in.op             = kct_pkg::op_e'(op_i);
    cmd_in.con.ip         = ip_addr_i;
    cmd_in.con.port       = port_num_i;
    cmd_in.con.alias_high = alias_high_i;
    cmd_in.con.alias_low  = alias_low_i;
    cmd_in.idx            = slot_index_i;
    cmd_in.null_con       = (ip_addr_i == '0) && (port_num_i == '0) &&
                            (alias_high_i == '0) && (alias_low_i == '0);
    cmd_in.in_range       = (32'(slot_index_i) < 32'(SLOTS));
  end

  kct_fifo #(
    .W     ($bits(kct_pkg::cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_flat),
    .empty_o (cmd_empty_o)
  );

  assign cmd_o = kct_pkg::cmd_t'(cmd_flat);

endmodule

[hdl/kct_back.sv]
// kct_back: slot store and scan sequencer that carries out queued requests.
// Depends on kct_pkg.
module kct_back #(
  parameter int SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  kct_pkg::cmd_t  cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  output kct_pkg::res_t  res_o,
  output logic           res_push_o,
  input  logic           res_full_i
);

  localparam int IW = $clog2(SLOTS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_LAST   = 5'b00100,
    S_RDWAIT = 5'b01000,
    S_EXEC   = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  kct_pkg::cmd_t     cmd_q;
  logic [IW-1:0]     cnt_q, cnt_d;
  logic              chk_vld_q;
  logic [IW-1:0]     chk_idx_q;
  logic [SLOTS-1:0]  occ_q;
  logic              match_found_q, free_found_q;
  logic [IW-1:0]     match_idx_q, free_idx_q;

  kct_pkg::contact_t mem_q [SLOTS];
  kct_pkg::contact_t rdata_q;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic              wr_en;
  logic              clr_en;
  logic [IW-1:0]     rd_idx;
  logic              chk_occ, chk_hit;
  logic              take;

  assign rd_idx  = IW'(cmd_i.idx);
  assign chk_occ = occ_q[chk_idx_q];
  assign chk_hit = chk_occ && (rdata_q.ip == cmd_q.con.ip) &&
                   (rdata_q.port == cmd_q.con.port);
  assign take    = (state_q == S_IDLE) && !cmd_empty_i;
  assign cmd_pop_o = take;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rd_en   = 1'b0;
    rd_addr = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cnt_d = '0;
          if (cmd_i.op == kct_pkg::OP_READ) begin
            if (cmd_i.in_range) begin
              rd_en   = 1'b1;
              rd_addr = rd_idx;
              state_d = S_RDWAIT;
            end else begin
              state_d = S_EXEC;
            end
          end else if (cmd_i.op == kct_pkg::OP_MERGE && cmd_i.null_con) begin
            state_d = S_EXEC;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_en = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == IW'(SLOTS - 1)) begin
          state_d = S_LAST;
        end
      end
      S_LAST:   state_d = S_EXEC;
      S_RDWAIT: state_d = S_EXEC;
      S_EXEC: begin
        if (!res_full_i) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Result and store update for the held request.
  always_comb begin
    res_o             = '0;
    res_o.status      = kct_pkg::STS_READ;
    wr_en             = 1'b0;
    clr_en            = 1'b0;
    case (cmd_q.op)
      kct_pkg::OP_MERGE, kct_pkg::OP_INSERT: begin
        if (cmd_q.op == kct_pkg::OP_MERGE && cmd_q.null_con) begin
          res_o.status = kct_pkg::STS_PRESENT;
        end else if (cmd_q.op == kct_pkg::OP_MERGE && match_found_q) begin
          res_o.status    = kct_pkg::STS_PRESENT;
          res_o.slot_used = 4'(match_idx_q);
        end else if (free_found_q) begin
          res_o.status    = kct_pkg::STS_ADDED;
          res_o.slot_used = 4'(free_idx_q);
          wr_en           = 1'b1;
        end else begin
          res_o.status = kct_pkg::STS_FULL;
        end
      end
      kct_pkg::OP_REMOVE: begin
        if (match_found_q) begin
          res_o.status    = kct_pkg::STS_REMOVED;
          res_o.slot_used = 4'(match_idx_q);
          clr_en          = 1'b1;
        end else begin
          res_o.status = kct_pkg::STS_NOT_FOUND;
        end
      end
      default: begin
        res_o.status    = kct_pkg::STS_READ;
        res_o.slot_used = cmd_q.idx;
        if (cmd_q.in_range && occ_q[IW'(cmd_q.idx)]) begin
          res_o.entry_valid = 1'b1;
          res_o.con         = rdata_q;
        end
      end
    endcase
  end

  assign res_push_o = (state_q == S_EXEC) && !res_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      chk_vld_q     <= 1'b0;
      occ_q         <= '0;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      chk_vld_q <= (state_q == S_SCAN);
      if (take) begin
        match_found_q <= 1'b0;
        free_found_q  <= 1'b0;
      end else if (chk_vld_q) begin
        if (chk_hit && !match_found_q) begin
          match_found_q <= 1'b1;
        end
        if (!chk_occ && !free_found_q) begin
          free_found_q <= 1'b1;
        end
      end
      // Slot is valid when anything in it is nonzero.
      if (res_push_o && wr_en) begin
        occ_q[free_idx_q] <= !cmd_q.null_con;
      end else if (res_push_o && clr_en) begin
        occ_q[match_idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= cnt_q;
    if (take) begin
      cmd_q <= cmd_i;
    end
    if (chk_vld_q && chk_hit && !match_found_q) begin
      match_idx_q <= chk_idx_q;
    end
    if (chk_vld_q && !chk_occ && !free_found_q) begin
      free_idx_q <= chk_idx_q;
    end
  end

  // Slot store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (res_push_o && wr_en) begin
      mem_q[free_idx_q] <= cmd_q.con;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

endmodule

[hdl/keyed_contact_table.sv]
// keyed_contact_table: top level of the keyed contact table.
// Depends on kct_pkg, kct_fifo, kct_front and kct_back.
//
// A table of SLOTS contact slots (alias, IPv4 address, port); a slot that is all
// zero is empty, and the key is address plus port. Requests enter through a
// queue-style port (push/full) and each produces exactly one result transaction,
// read out in order through a queue-style port (empty/pop). Ops: merge inserts
// into the first empty slot unless the key is already held (an all-zero contact
// is ignored), insert skips the duplicate check, remove clears the first slot
// holding the key, read returns one slot. The front end classifies requests into
// a two-entry queue; the back end walks the slot store one slot per cycle through
// its single registered read port. Merge, insert and remove scan every slot
// before their result is written to the result queue; a read first fetches its
// one slot, while a read whose slot_index is not below SLOTS and an ignored null
// merge go straight to the result. A full result queue holds the result back.
// Requests are carried out one at a time: a new request is taken only once the
// last result is written. The store is empty right after reset with no clearing
// pass: a per-slot valid flop, cleared by reset, masks the store contents.
module keyed_contact_table #(
  parameter int SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op_i,
  input  logic [31:0] ip_addr_i,
  input  logic [15:0] port_num_i,
  input  logic [63:0] alias_high_i,
  input  logic [63:0] alias_low_i,
  input  logic [3:0]  slot_index_i,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [3:0]  slot_used_o,
  output logic        entry_valid_o,
  output logic [31:0] read_ip_o,
  output logic [15:0] read_port_o,
  output logic [63:0] read_alias_high_o,
  output logic [63:0] read_alias_low_o
);

  kct_pkg::cmd_t cmd;
  logic          cmd_empty;
  logic          cmd_pop;
  kct_pkg::res_t res_in;
  logic          res_push;
  logic          res_full;
  logic [$bits(kct_pkg::res_t)-1:0] res_flat;
  kct_pkg::res_t res_out;

  // Accept and classify.
  kct_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .op_i         (op_i),
    .ip_addr_i    (ip_addr_i),
    .port_num_i   (port_num_i),
    .alias_high_i (alias_high_i),
    .alias_low_i  (alias_low_i),
    .slot_index_i (slot_index_i),
    .cmd_pop_i    (cmd_pop),
    .cmd_o        (cmd),
    .cmd_empty_o  (cmd_empty)
  );

  // Scan and update the slot store.
  kct_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // Result queue decouples the back end from the consumer.
  kct_fifo #(
    .W     ($bits(kct_pkg::res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_flat),
    .empty_o (empty)
  );

  assign res_out           = kct_pkg::res_t'(res_flat);
  assign status_o          = res_out.status;
  assign slot_used_o       = res_out.slot_used;
  assign entry_valid_o     = res_out.entry_valid;
  assign read_ip_o         = res_out.con.ip;
  assign read_port_o       = res_out.con.port;
  assign read_alias_high_o = res_out.con.alias_high;
  assign read_alias_low_o  = res_out.con.alias_low;

endmodule
